// File: rtl/ptt_pkg.sv
`default_nettype none

package ptt_pkg;

   localparam logic [2:0] EV_NONE   = 3'd0;
   localparam logic [2:0] EV_SHORT  = 3'd1;
   localparam logic [2:0] EV_START  = 3'd2;
   localparam logic [2:0] EV_STOP   = 3'd3;
   localparam logic [2:0] EV_LIMIT  = 3'd4;
   localparam logic [2:0] EV_STORED = 3'd5;

   localparam logic CMD_TICK   = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   localparam logic LEVEL_PRESSED  = 1'b0;
   localparam logic LEVEL_RELEASED = 1'b1;

   localparam logic [1:0] CSR_DEBOUNCE   = 2'd0;
   localparam logic [1:0] CSR_LONG_PRESS = 2'd1;
   localparam logic [1:0] CSR_MAX_SAMPLE = 2'd2;

   localparam logic [9:0]  STABLE_MAX = 10'h3FF;
   localparam logic [15:0] HELD_MAX   = 16'hFFFF;

   localparam logic [9:0]  DEBOUNCE_RESET   = 10'd50;
   localparam logic [15:0] LONG_PRESS_RESET = 16'd500;
   localparam logic [20:0] MAX_SAMPLE_RESET = 21'd160000;

   localparam logic signed [15:0] SAMPLE_POS_MAX = 16'sh7FFF;
   localparam logic signed [15:0] SAMPLE_NEG_MAX = -16'sh8000;

   typedef struct packed {
      logic [9:0]  debounce_ticks;
      logic [15:0] long_press_ticks;
      logic [20:0] limit;
   } cfg_type;

   typedef struct packed {
      logic               cmd;
      logic               button_level;
      logic signed [15:0] sample_in;
   } item_type;

   typedef struct packed {
      logic        last_raw_level;
      logic [9:0]  stable_ticks;
      logic        pressed;
      logic [15:0] held_ticks;
      logic        recording;
      logic        capture_on;
      logic [20:0] sample_count;
   } state_type;

   typedef struct packed {
      logic [2:0]         event_res;
      logic signed [15:0] sample_out;
      logic [19:0]        write_index;
      logic [20:0]        samples_recorded;
   } result_type;

endpackage

`default_nettype wire

// File: rtl/ptt_step.sv
`default_nettype none

module ptt_step (
   input  var ptt_pkg::cfg_type    cfg,
   input  var ptt_pkg::state_type  cur,
   input  var ptt_pkg::item_type   item,
   output ptt_pkg::state_type      nxt,
   output ptt_pkg::result_type     res
);

   logic accepted;
   logic same_sign;

   assign same_sign = (item.sample_in[15:12] == 4'b0000) || (item.sample_in[15:12] == 4'b1111);

   always_comb begin
      nxt      = cur;
      res      = '0;
      accepted = 1'b0;
      res.event_res = ptt_pkg::EV_NONE;
      if (item.cmd == ptt_pkg::CMD_SAMPLE) begin
         if (cur.capture_on && (cur.sample_count < cfg.limit)) begin
            if (same_sign) begin
               res.sample_out = {item.sample_in[12:0], 3'b000};
            end else if (item.sample_in[15]) begin
               res.sample_out = ptt_pkg::SAMPLE_NEG_MAX;
            end else begin
               res.sample_out = ptt_pkg::SAMPLE_POS_MAX;
            end
            res.write_index  = cur.sample_count[19:0];
            nxt.sample_count = cur.sample_count + 21'd1;
            res.event_res    = ptt_pkg::EV_STORED;
         end
      end else begin
         if (cur.pressed && (cur.held_ticks != ptt_pkg::HELD_MAX)) begin
            nxt.held_ticks = cur.held_ticks + 16'd1;
         end
         if (item.button_level != cur.last_raw_level) begin
            nxt.stable_ticks = '0;
         end else if (cur.stable_ticks != ptt_pkg::STABLE_MAX) begin
            nxt.stable_ticks = cur.stable_ticks + 10'd1;
         end
         nxt.last_raw_level = item.button_level;
         accepted = (nxt.stable_ticks > cfg.debounce_ticks) ||
                    (nxt.stable_ticks == ptt_pkg::STABLE_MAX);
         if (accepted) begin
            if ((item.button_level == ptt_pkg::LEVEL_PRESSED) && !cur.pressed) begin
               nxt.pressed    = 1'b1;
               nxt.held_ticks = '0;
            end else if ((item.button_level == ptt_pkg::LEVEL_RELEASED) && cur.pressed) begin
               nxt.pressed = 1'b0;
               if (cur.recording) begin
                  nxt.recording  = 1'b0;
                  nxt.capture_on = 1'b0;
                  res.event_res  = ptt_pkg::EV_STOP;
               end else if (nxt.held_ticks < cfg.long_press_ticks) begin
                  res.event_res  = ptt_pkg::EV_SHORT;
               end
            end
         end
         if (res.event_res == ptt_pkg::EV_NONE) begin
            if (nxt.pressed && !nxt.recording && (nxt.held_ticks >= cfg.long_press_ticks)) begin
               nxt.recording    = 1'b1;
               nxt.capture_on   = 1'b1;
               nxt.sample_count = '0;
               res.event_res    = ptt_pkg::EV_START;
            end else if (nxt.recording && nxt.pressed && nxt.capture_on &&
                         (nxt.sample_count >= cfg.limit)) begin
               nxt.capture_on = 1'b0;
               res.event_res  = ptt_pkg::EV_LIMIT;
            end
         end
      end
      res.samples_recorded = nxt.sample_count;
   end

endmodule

`default_nettype wire

// File: rtl/push_to_talk_capture_controller.sv
// Push-to-talk capture controller.
// req_ carries one item per handshake: a one-millisecond tick with the raw,
// active-low button level, or a signed audio sample. rsp_ returns exactly
// one result item per request item, in order: an event code on rsp_tuser
// with the scaled sample, its buffer position and the running sample count.
// csr_ writes the debounce time, the long-press time and the sample limit;
// write it only while no item is in flight.
// An accepted item passes one input register, then the state update and result
// register, where rsp_tvalid rises; while that register is full and rsp_tready is
// low, the item waits in the input register. One item is taken every cycle while rsp_tready is high.
// When rsp_tready is low the result register holds and the input register
// takes one more item; req_tready falls only when both are full.
// Synchronous reset empties both registers, loads the register defaults
// and returns the button to released with capture off.
// The sample limit is the lesser of the written limit and BUFFER_DEPTH.
`default_nettype none

module push_to_talk_capture_controller #(
   parameter int unsigned BUFFER_DEPTH = 1048576
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,  // button_level, sample_in, zero pad
   input  wire logic        req_tuser,  // cmd
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,  // sample_out, write_index, samples_recorded, zero pad
   output logic [2:0]       rsp_tuser,  // event_res
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [20:0] csr_wdata
);

   localparam logic [24:0] DEPTH_LIMIT = 25'(BUFFER_DEPTH);

   logic [9:0]  debounce_ff;
   logic [15:0] long_press_ff;
   logic [20:0] max_samples_ff;

   logic                 in_valid_ff;
   ptt_pkg::item_type    in_item_ff;
   logic                 rsp_valid_ff;
   ptt_pkg::result_type  rsp_res_ff;
   ptt_pkg::state_type   state_ff;
   ptt_pkg::state_type   state_in;
   ptt_pkg::result_type  rsp_res_in;
   ptt_pkg::item_type    req_item;
   ptt_pkg::cfg_type     cfg;

   logic [24:0] limit_wide;
   logic        advance;

   assign limit_wide = ({4'b0, max_samples_ff} > DEPTH_LIMIT) ? DEPTH_LIMIT
                                                              : {4'b0, max_samples_ff};

   assign cfg.debounce_ticks   = debounce_ff;
   assign cfg.long_press_ticks = long_press_ff;
   assign cfg.limit            = limit_wide[20:0];

   assign req_item.cmd          = req_tuser;
   assign req_item.button_level = req_tdata[0];
   assign req_item.sample_in    = signed'(req_tdata[16:1]);

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   ptt_step u_step (
      .cfg  (cfg),
      .cur  (state_ff),
      .item (in_item_ff),
      .nxt  (state_in),
      .res  (rsp_res_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff    <= ptt_pkg::DEBOUNCE_RESET;
         long_press_ff  <= ptt_pkg::LONG_PRESS_RESET;
         max_samples_ff <= ptt_pkg::MAX_SAMPLE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            ptt_pkg::CSR_DEBOUNCE:   debounce_ff    <= csr_wdata[9:0];
            ptt_pkg::CSR_LONG_PRESS: long_press_ff  <= csr_wdata[15:0];
            ptt_pkg::CSR_MAX_SAMPLE: max_samples_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '{last_raw_level: ptt_pkg::LEVEL_RELEASED, default: '0};
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // hold payloads while stalled
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_item_ff <= req_item;
      end
      if (advance) begin
         rsp_res_ff <= rsp_res_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_res_ff.event_res;
   assign rsp_tdata  = {7'b0, rsp_res_ff.samples_recorded, rsp_res_ff.write_index,
                        rsp_res_ff.sample_out};

   a_capture_needs_recording: assert property (@(posedge clock) disable iff (reset)
      state_ff.capture_on |-> state_ff.recording)
      else $error("capture on without recording");

   a_recording_needs_press: assert property (@(posedge clock) disable iff (reset)
      state_ff.recording |-> state_ff.pressed)
      else $error("recording without a debounced press");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (in_valid_ff && rsp_valid_ff && !rsp_tready))
      else $error("request stalled with free space");

   a_stored_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_res_ff.event_res == ptt_pkg::EV_STORED)) |->
      ((rsp_res_ff.write_index + 20'd1) == rsp_res_ff.samples_recorded[19:0]))
      else $error("write index does not match sample count");

endmodule

`default_nettype wire

// File: dv/ptt_capture_checker.sv
module ptt_capture_checker #(
   parameter int unsigned BUFFER_DEPTH = 1048576
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,  // button_level, sample_in, zero pad
   input  logic        req_tuser,  // cmd
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [63:0] rsp_tdata,  // sample_out, write_index, samples_recorded, zero pad
   input  logic [2:0]  rsp_tuser,  // event_res
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [20:0] csr_wdata,
   output int          fail_count,
   output int          pending,
   output int          checked
);

   ptt_pkg::cfg_type    cfg;
   ptt_pkg::state_type  st;
   ptt_pkg::result_type pending_outcomes[$];

   function automatic ptt_pkg::result_type capture_outcome(ptt_pkg::item_type it);
      ptt_pkg::result_type r;
      logic [20:0] lim;
      logic        accepted;
      int          scaled;
      r = '0;
      r.event_res = ptt_pkg::EV_NONE;
      if (cfg.limit > BUFFER_DEPTH) lim = 21'(BUFFER_DEPTH);
      else lim = cfg.limit;

      if (it.cmd == ptt_pkg::CMD_SAMPLE) begin
         if (st.capture_on && st.sample_count < lim) begin
            scaled = $signed(it.sample_in) * 8;
            if (scaled > int'(ptt_pkg::SAMPLE_POS_MAX)) scaled = int'(ptt_pkg::SAMPLE_POS_MAX);
            if (scaled < int'(ptt_pkg::SAMPLE_NEG_MAX)) scaled = int'(ptt_pkg::SAMPLE_NEG_MAX);
            r.sample_out = scaled[15:0];
            r.write_index = st.sample_count[19:0];
            st.sample_count = st.sample_count + 21'd1;
            r.event_res = ptt_pkg::EV_STORED;
         end
      end else begin
         if (st.pressed && st.held_ticks != ptt_pkg::HELD_MAX)
            st.held_ticks = st.held_ticks + 16'd1;
         if (it.button_level != st.last_raw_level) st.stable_ticks = '0;
         else if (st.stable_ticks != ptt_pkg::STABLE_MAX)
            st.stable_ticks = st.stable_ticks + 10'd1;
         st.last_raw_level = it.button_level;

         accepted = (st.stable_ticks > cfg.debounce_ticks) ||
                    (st.stable_ticks == ptt_pkg::STABLE_MAX);
         if (accepted) begin
            if (it.button_level == ptt_pkg::LEVEL_PRESSED && !st.pressed) begin
               st.pressed = 1'b1;
               st.held_ticks = '0;
            end else if (it.button_level == ptt_pkg::LEVEL_RELEASED && st.pressed) begin
               st.pressed = 1'b0;
               if (st.recording) begin
                  st.recording = 1'b0;
                  st.capture_on = 1'b0;
                  r.event_res = ptt_pkg::EV_STOP;
               end else if (st.held_ticks < cfg.long_press_ticks) begin
                  r.event_res = ptt_pkg::EV_SHORT;
               end
            end
         end

         if (r.event_res == ptt_pkg::EV_NONE) begin
            if (st.pressed && !st.recording && st.held_ticks >= cfg.long_press_ticks) begin
               st.recording = 1'b1;
               st.capture_on = 1'b1;
               st.sample_count = '0;
               r.event_res = ptt_pkg::EV_START;
            end else if (st.recording && st.pressed && st.capture_on
                         && st.sample_count >= lim) begin
               st.capture_on = 1'b0;
               r.event_res = ptt_pkg::EV_LIMIT;
            end
         end
      end
      r.samples_recorded = st.sample_count;
      return r;
   endfunction

   task automatic check_field(input string name, input longint want, input longint seen);
      if (want != seen) begin
         $error("%s: expected %0d, got %0d", name, want, seen);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : watch
      ptt_pkg::item_type   it;
      ptt_pkg::result_type want;
      if (reset) begin
         cfg.debounce_ticks = ptt_pkg::DEBOUNCE_RESET;
         cfg.long_press_ticks = ptt_pkg::LONG_PRESS_RESET;
         cfg.limit = ptt_pkg::MAX_SAMPLE_RESET;
         st = '0;
         st.last_raw_level = ptt_pkg::LEVEL_RELEASED;
         pending_outcomes.delete();
         fail_count = 0;
         pending = 0;
         checked = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               ptt_pkg::CSR_DEBOUNCE:   cfg.debounce_ticks = csr_wdata[9:0];
               ptt_pkg::CSR_LONG_PRESS: cfg.long_press_ticks = csr_wdata[15:0];
               ptt_pkg::CSR_MAX_SAMPLE: cfg.limit = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pending_outcomes.size() == 0) begin
               $error("result item with nothing expected: event_res %0d", rsp_tuser);
               fail_count++;
            end else begin
               want = pending_outcomes.pop_front();
               check_field("event_res", want.event_res, rsp_tuser);
               check_field("sample_out", want.sample_out, $signed(rsp_tdata[15:0]));
               check_field("write_index", want.write_index, rsp_tdata[35:16]);
               check_field("samples_recorded", want.samples_recorded, rsp_tdata[56:36]);
               checked++;
            end
         end
         if (req_tvalid && req_tready) begin
            it.cmd = req_tuser;
            it.button_level = req_tdata[0];
            it.sample_in = req_tdata[16:1];
            pending_outcomes.push_back(capture_outcome(it));
         end
         pending = pending_outcomes.size();
      end
   end

endmodule

// File: dv/push_to_talk_capture_controller_tb.sv
module push_to_talk_capture_controller_tb;

   localparam int unsigned DEPTH = 1048576;
   localparam logic [1:0] CSR_SPARE = 2'd3;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [20:0] csr_wdata;

   int fail_count;
   int pending;
   int checked;
   int items_sent = 0;
   int settings_used = 0;
   int cur_deb = 50;
   int cur_long = 500;
   bit send_quiet = 1'b0;
   bit rsp_quiet = 1'b0;

   push_to_talk_capture_controller #(.BUFFER_DEPTH(DEPTH)) dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   ptt_capture_checker #(.BUFFER_DEPTH(DEPTH)) u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending(pending), .checked(checked)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("== FAIL ==");
      $finish;
   end

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(6, 20);
   endfunction

   // result side: ready runs of random length, broken by stalls
   initial begin
      int stall;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_tready <= 1'b1;
         repeat ($urandom_range(0, 30)) @(negedge clock);
         stall = rsp_quiet ? 0 : idle_len();
         if (stall > 0) begin
            @(negedge clock);
            rsp_tready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end
      end
   end

   task automatic send(input logic cmd, input logic lvl, input logic signed [15:0] smp);
      int gap;
      @(negedge clock);
      gap = send_quiet ? 0 : idle_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tuser <= cmd;
      req_tdata <= {7'd0, smp, lvl};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   task automatic pin_tick(input logic lvl);
      send(ptt_pkg::CMD_TICK, lvl, 16'($urandom));
   endtask

   task automatic mic(input logic signed [15:0] v);
      send(ptt_pkg::CMD_SAMPLE, 1'($urandom), v);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic apply_settings(input int deb, input int lp, input int mx);
      wait_idle();
      csr_we <= 1'b1;
      csr_index <= ptt_pkg::CSR_DEBOUNCE;
      csr_wdata <= 21'(deb);
      @(negedge clock);
      csr_index <= ptt_pkg::CSR_LONG_PRESS;
      csr_wdata <= 21'(lp);
      @(negedge clock);
      csr_index <= ptt_pkg::CSR_MAX_SAMPLE;
      csr_wdata <= 21'(mx);
      @(negedge clock);
      csr_index <= CSR_SPARE;
      csr_wdata <= 21'($urandom);
      @(negedge clock);
      csr_we <= 1'b0;
      cur_deb = deb;
      cur_long = lp;
      settings_used++;
   endtask

   // bounce, hold with audio interleaved, bounce, settle released
   task automatic press_run();
      int hold;
      repeat ($urandom_range(0, 3)) pin_tick(1'($urandom));
      if ($urandom_range(0, 2) == 0) hold = $urandom_range(1, cur_deb + cur_long + 1);
      else hold = cur_deb + cur_long + $urandom_range(1, 24);
      repeat (hold) begin
         pin_tick(ptt_pkg::LEVEL_PRESSED);
         repeat ($urandom_range(0, 3)) mic(16'($urandom));
      end
      repeat ($urandom_range(0, 3)) pin_tick(1'($urandom));
      repeat (cur_deb + $urandom_range(1, 4)) begin
         pin_tick(ptt_pkg::LEVEL_RELEASED);
         if ($urandom_range(0, 3) == 0) mic(16'($urandom));
      end
   endtask

   initial begin
      int p;
      int goal;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = ptt_pkg::CMD_TICK;
      csr_we = 1'b0;
      csr_index = ptt_pkg::CSR_DEBOUNCE;
      csr_wdata = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // audio with capture off, under reset settings
      mic(ptt_pkg::SAMPLE_POS_MAX);
      pin_tick(ptt_pkg::LEVEL_RELEASED);

      apply_settings(0, 3, 3);
      repeat (5) pin_tick(ptt_pkg::LEVEL_PRESSED);
      mic(ptt_pkg::SAMPLE_POS_MAX);
      mic(ptt_pkg::SAMPLE_NEG_MAX);
      mic(16'sd4095);
      mic(16'sd4096);
      pin_tick(ptt_pkg::LEVEL_PRESSED);
      mic(16'sd0);
      repeat (2) pin_tick(ptt_pkg::LEVEL_RELEASED);
      repeat (2) pin_tick(ptt_pkg::LEVEL_PRESSED);
      repeat (2) pin_tick(ptt_pkg::LEVEL_RELEASED);
      mic(-16'sd4097);

      for (p = 0; p < 6; p++) begin
         case (p)
            0: apply_settings(0, 1, 0);
            1: apply_settings(0, 1, 1);
            5: apply_settings($urandom_range(1, 4), $urandom_range(2, 12), 2097151);
            default: apply_settings($urandom_range(0, 4), $urandom_range(1, 12),
                                    $urandom_range(1, 30));
         endcase
         goal = items_sent + 85;
         while (items_sent < goal) begin
            send_quiet = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 4) != 0) begin
               press_run();
            end else begin
               repeat ($urandom_range(3, 12))
                  send(1'($urandom), 1'($urandom), 16'($urandom));
            end
         end
      end

      // widest register values: the press stays unqualified
      apply_settings(1023, 65535, 2097151);
      send_quiet = 1'b1;
      rsp_quiet = 1'b1;
      repeat (30) pin_tick(ptt_pkg::LEVEL_PRESSED);
      repeat (10) mic(16'($urandom));
      repeat (10) pin_tick(ptt_pkg::LEVEL_RELEASED);
      send_quiet = 1'b0;
      rsp_quiet = 1'b0;

      wait_idle();
      $display("%0d items driven across %0d register settings, %0d results compared",
               items_sent, settings_used, checked);
      $display("short and long presses, capture limits incl. zero and clamped, widest settings");
      if (fail_count == 0 && pending == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/ptt_pkg.sv
rtl/ptt_step.sv
rtl/push_to_talk_capture_controller.sv
dv/ptt_capture_checker.sv
dv/push_to_talk_capture_controller_tb.sv
